// ----- rtl/spe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spe_pkg
// Shared constants and the arctangent table function for the sine positional embedding block.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int MAX_FEATS    = 128;
    localparam int CORDIC_STEPS = 16;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int CW  = 7;

    localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
    localparam logic [34:0] PI_Q32      = 35'd13493037705;
    localparam logic [34:0] HALF_PI_Q32 = 35'd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FEATS  = 3'd2;
    localparam logic [2:0] REG_NORM   = 3'd3;
    localparam logic [2:0] REG_SCALE  = 3'd4;
    localparam logic [2:0] REG_RATIO  = 3'd5;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0: r = 34'sd843314857;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043837;
            5'd3: r = 34'sd133525159;
            5'd4: r = 34'sd67021687;
            5'd5: r = 34'sd33543516;
            5'd6: r = 34'sd16775851;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194283;
            5'd9: r = 34'sd2097149;
            5'd31: r = 34'sd0;
            default: r = 34'sd1 <<< (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sine_positional_embedding.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sine_positional_embedding
// Mask loader with running row/column counts and a sine/cosine query engine.
// ----------------------------------------------------------------------------
// A load beat (tuser=0) stores one mask bit in raster order with one memory
// read-modify-write of the column counter. A query beat (tuser=1) returns
// one result beat: it reads the count stores, divides by the axis total
// when normalization is on (restoring divider), raises the frequency ratio
// to floor(j/2) by repeated 33x32 multiplies split into two 33x16 halves,
// forms the angle, reduces it modulo 2*pi in eight shift-and-subtract steps
// plus a fold into the first quadrant, then runs 16 CORDIC rotations one
// per cycle. Query errors return at once. The block takes no beat while a
// load or query is in work, nor while a finished result waits unaccepted
// in the output register.
// Count stores are not cleared: pixels never loaded read undefined values.
// ----------------------------------------------------------------------------
module sine_positional_embedding (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // mask_bit, query_x[5:0], query_y[5:0], feat_index[7:0]
    input  wire         s_tuser,   // req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // embed_value[15:0]
    output logic        m_tuser,   // query_error
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    localparam int XW = spe_pkg::XW;
    localparam int YW = spe_pkg::YW;
    localparam int AW = spe_pkg::AW;
    localparam int CW = spe_pkg::CW;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_LOAD  = 11'b00000000010,
        ST_READ  = 11'b00000000100,
        ST_SEL   = 11'b00000001000,
        ST_DIV   = 11'b00000010000,
        ST_MULLO = 11'b00000100000,
        ST_MULHI = 11'b00001000000,
        ST_ANG   = 11'b00010000000,
        ST_RED   = 11'b00100000000,
        ST_CORD  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [6:0]  width_reg, height_reg;
    logic [7:0]  feats_reg;
    logic        norm_reg;
    logic [15:0] scale_reg;
    logic [31:0] ratio_reg;

    // load state
    logic [XW-1:0] load_x_reg;
    logic [YW-1:0] load_y_reg;
    logic [CW-1:0] row_run_reg;
    logic          load_done_reg;
    logic          ld_bit_reg;

    // memories
    logic [CW-1:0] row_mem [0:(1<<AW)-1];
    logic [CW-1:0] col_mem [0:(1<<AW)-1];
    logic [CW-1:0] col_run_mem [0:(1<<XW)-1];
    logic [CW-1:0] row_tot_mem [0:(1<<YW)-1];
    logic [CW-1:0] rd_row_reg, rd_col_reg, rd_crun_reg, rd_rtot_reg;

    // query
    logic          use_x_reg, want_cos_reg;
    logic [6:0]    pairs_reg;
    logic [CW-1:0] tot_reg;
    logic [26:0]   rem_reg;
    logic [26:0]   pos_reg;
    logic [4:0]    cnt5_reg;
    logic [32:0]   fac_reg;
    logic [47:0]   plo_reg;
    logic [42:0]   ang_reg;
    logic          sneg_reg, cneg_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [15:0]   out_val_reg;
    logic          out_err_reg;
    logic          m_valid_reg;

    // decoded config
    logic [6:0] w_eff, h_eff;
    logic [7:0] f_eff;
    always_comb begin
        w_eff = (width_reg == 7'd0) ? 7'd1 :
                (width_reg > 7'(spe_pkg::MAX_WIDTH)) ? 7'(spe_pkg::MAX_WIDTH) : width_reg;
        h_eff = (height_reg == 7'd0) ? 7'd1 :
                (height_reg > 7'(spe_pkg::MAX_HEIGHT)) ? 7'(spe_pkg::MAX_HEIGHT) : height_reg;
        f_eff = (feats_reg < 8'd2) ? 8'd2 :
                (feats_reg > 8'(spe_pkg::MAX_FEATS)) ? 8'(spe_pkg::MAX_FEATS) : feats_reg;
        f_eff = {f_eff[7:1], 1'b0};
    end

    logic       in_mask;
    logic [5:0] in_qx, in_qy;
    logic [7:0] in_k;
    assign in_mask = s_tdata[0];
    assign in_qx   = s_tdata[6:1];
    assign in_qy   = s_tdata[12:7];
    assign in_k    = s_tdata[20:13];

    logic accept;
    assign s_tready  = (state_reg == ST_IDLE) && !(m_valid_reg && !m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // load position after restart
    logic [XW-1:0] lx;
    logic [YW-1:0] ly;
    assign lx = load_done_reg ? '0 : load_x_reg;
    assign ly = load_done_reg ? '0 : load_y_reg;

    // query error check
    logic       q_err;
    logic [8:0] k_ext;
    assign k_ext = {1'b0, in_k};
    assign q_err = !load_done_reg || ({1'b0, in_qx} >= w_eff) ||
                   ({1'b0, in_qy} >= h_eff) || (k_ext >= {f_eff, 1'b0});

    // output register load: error beat at accept or finished query
    logic out_load;
    assign out_load = (accept && s_tuser && q_err) ||
                      ((state_reg == ST_OUT) && (!m_valid_reg || m_tready));

    // load update values (ST_LOAD)
    logic [CW-1:0] rr, cr;
    assign rr = ((load_x_reg == '0) ? '0 : row_run_reg) + CW'(ld_bit_reg);
    assign cr = ((load_y_reg == '0) ? '0 : rd_crun_reg) + CW'(ld_bit_reg);

    // memory reads
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_crun_reg <= col_run_mem[s_tuser ? in_qx[XW-1:0] : lx];
            rd_row_reg  <= row_mem[{in_qy[YW-1:0], in_qx[XW-1:0]}];
            rd_col_reg  <= col_mem[{in_qy[YW-1:0], in_qx[XW-1:0]}];
            rd_rtot_reg <= row_tot_mem[in_qy[YW-1:0]];
        end
        if (state_reg == ST_LOAD) begin
            row_mem[{load_y_reg, load_x_reg}] <= rr;
            col_mem[{load_y_reg, load_x_reg}] <= cr;
            col_run_mem[load_x_reg] <= cr;
            if ({1'b0, load_x_reg} + 7'd1 >= w_eff)
                row_tot_mem[load_y_reg] <= rr;
        end
    end

    // selected count and normalization dividend (count*scale < 2^22)
    logic [CW-1:0] sel_cnt;
    logic [22:0]   norm_prod;
    assign sel_cnt   = use_x_reg ? rd_row_reg : rd_col_reg;
    assign norm_prod = sel_cnt * scale_reg;

    // shared multiplier: 33 x 16
    logic [15:0] mul_b;
    logic [48:0] mul_p;
    assign mul_b = (state_reg == ST_MULLO) ? ratio_reg[15:0] : ratio_reg[31:16];
    assign mul_p = fac_reg * mul_b;

    // divider step
    logic [27:0] div_try;
    assign div_try = {rem_reg, pos_reg[26]} - {21'd0, tot_reg};

    // modulo 2*pi reduction: subtract 2*pi << (cnt5-1) where it fits while cnt5 counts down
    logic [42:0] red_sub;
    logic [34:0] ang_lo;
    assign red_sub = {8'd0, spe_pkg::TWO_PI_Q32} << (cnt5_reg - 5'd1);
    assign ang_lo  = ang_reg[34:0];

    // CORDIC step
    logic signed [33:0] dx, dy, at;
    assign dx = cy_reg >>> cnt5_reg;
    assign dy = cx_reg >>> cnt5_reg;
    assign at = spe_pkg::atan_q30(cnt5_reg);

    logic signed [34:0] rnd_in, rnd_sh;
    logic signed [15:0] q14;
    always_comb begin
        rnd_in = want_cos_reg ? 35'(cx_reg) : 35'(cy_reg);
        rnd_sh = (rnd_in + 35'sd32768) >>> 16;
        if (rnd_sh > 35'sd16384)       q14 = 16'sd16384;
        else if (rnd_sh < -35'sd16384) q14 = -16'sd16384;
        else                           q14 = rnd_sh[15:0];
        if (want_cos_reg ? cneg_reg : sneg_reg) q14 = -q14;
    end

    logic [58:0] angle_full;
    assign angle_full = pos_reg * fac_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) begin
                if (!s_tuser)   state_next = ST_LOAD;
                else if (q_err) state_next = ST_IDLE;
                else            state_next = ST_SEL;
            end
            ST_LOAD:  state_next = ST_IDLE;
            ST_READ:  state_next = ST_SEL;
            ST_SEL:   state_next = norm_reg ? ST_DIV : (pairs_reg != 7'd0 ? ST_MULLO : ST_ANG);
            ST_DIV:   if (cnt5_reg == 5'd26)
                          state_next = (pairs_reg != 7'd0) ? ST_MULLO : ST_ANG;
            ST_MULLO: state_next = ST_MULHI;
            ST_MULHI: state_next = (pairs_reg == 7'd1) ? ST_ANG : ST_MULLO;
            ST_ANG:   state_next = ST_RED;
            ST_RED:   if (cnt5_reg == 5'd0) state_next = ST_CORD;
            ST_CORD:  if (cnt5_reg == 5'(spe_pkg::CORDIC_STEPS - 1)) state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            width_reg     <= 7'd64;
            height_reg    <= 7'd64;
            feats_reg     <= 8'd128;
            norm_reg      <= 1'b0;
            scale_reg     <= 16'd25736;
            ratio_reg     <= 32'd3719300000;
            load_x_reg    <= '0;
            load_y_reg    <= '0;
            row_run_reg   <= '0;
            load_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    spe_pkg::REG_WIDTH:  width_reg  <= cfg_data[6:0];
                    spe_pkg::REG_HEIGHT: height_reg <= cfg_data[6:0];
                    spe_pkg::REG_FEATS:  feats_reg  <= cfg_data[7:0];
                    spe_pkg::REG_NORM:   norm_reg   <= cfg_data[0];
                    spe_pkg::REG_SCALE:  scale_reg  <= cfg_data[15:0];
                    spe_pkg::REG_RATIO:  ratio_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (accept) begin
                if (!s_tuser) begin
                    ld_bit_reg <= in_mask;
                    if (load_done_reg) begin
                        load_done_reg <= 1'b0;
                        load_x_reg    <= '0;
                        load_y_reg    <= '0;
                    end
                end else begin
                    use_x_reg    <= (k_ext >= {1'b0, f_eff});
                    if (k_ext >= {1'b0, f_eff}) begin
                        pairs_reg    <= 7'((k_ext - {1'b0, f_eff}) >> 1);
                        want_cos_reg <= in_k[0] ^ f_eff[0];
                    end else begin
                        pairs_reg    <= in_k[7:1];
                        want_cos_reg <= in_k[0];
                    end
                    if (q_err) begin
                        out_val_reg <= '0;
                        out_err_reg <= 1'b1;
                    end
                end
            end
            unique case (state_reg)
                ST_LOAD: begin
                    row_run_reg <= rr;
                    if ({1'b0, load_x_reg} + 7'd1 >= w_eff) begin
                        load_x_reg <= '0;
                        if ({1'b0, load_y_reg} + 7'd1 >= h_eff) begin
                            load_done_reg <= 1'b1;
                            load_y_reg    <= '0;
                        end else begin
                            load_y_reg <= load_y_reg + 1'b1;
                        end
                    end else begin
                        load_x_reg <= load_x_reg + 1'b1;
                    end
                end
                ST_SEL: begin
                    tot_reg  <= use_x_reg ? rd_rtot_reg : rd_crun_reg;
                    fac_reg  <= 33'h1_0000_0000;
                    cnt5_reg <= '0;
                    rem_reg  <= '0;
                    pos_reg  <= norm_reg ? {norm_prod, 4'd0} : {4'd0, sel_cnt, 16'd0};
                end
                ST_DIV: begin
                    cnt5_reg <= cnt5_reg + 5'd1;
                    if (tot_reg == '0) begin
                        pos_reg <= '0;
                    end else if (!div_try[27]) begin
                        rem_reg <= div_try[26:0];
                        pos_reg <= {pos_reg[25:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[25:0], pos_reg[26]};
                        pos_reg <= {pos_reg[25:0], 1'b0};
                    end
                end
                ST_MULLO: plo_reg <= mul_p[47:0];
                ST_MULHI: begin
                    fac_reg   <= 33'(({mul_p, 16'd0} + {17'd0, plo_reg}) >> 32);
                    pairs_reg <= pairs_reg - 7'd1;
                end
                ST_ANG: begin
                    // angle below 2^42, quotient by 2*pi below 256
                    ang_reg  <= angle_full[58:16];
                    cnt5_reg <= 5'd8;
                end
                ST_RED: begin
                    if (cnt5_reg != 5'd0) begin
                        cnt5_reg <= cnt5_reg - 5'd1;
                        if (ang_reg >= red_sub)
                            ang_reg <= ang_reg - red_sub;
                    end else begin
                        cx_reg <= spe_pkg::CORDIC_GAIN_Q30;
                        cy_reg <= '0;
                        if (ang_lo >= spe_pkg::PI_Q32) begin
                            sneg_reg <= 1'b1;
                            if (ang_lo - spe_pkg::PI_Q32 > spe_pkg::HALF_PI_Q32) begin
                                cneg_reg <= 1'b0;
                                cz_reg <= 34'((spe_pkg::TWO_PI_Q32 - ang_lo) >> 2);
                            end else begin
                                cneg_reg <= 1'b1;
                                cz_reg <= 34'((ang_lo - spe_pkg::PI_Q32) >> 2);
                            end
                        end else begin
                            sneg_reg <= 1'b0;
                            if (ang_lo > spe_pkg::HALF_PI_Q32) begin
                                cneg_reg <= 1'b1;
                                cz_reg <= 34'((spe_pkg::PI_Q32 - ang_lo) >> 2);
                            end else begin
                                cneg_reg <= 1'b0;
                                cz_reg <= 34'(ang_lo >> 2);
                            end
                        end
                    end
                end
                ST_CORD: begin
                    cnt5_reg <= cnt5_reg + 5'd1;
                    if (cz_reg >= 0) begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - at;
                    end else begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + at;
                    end
                end
                ST_OUT: if (!m_valid_reg || m_tready) begin
                    out_val_reg <= q14;
                    out_err_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_err_reg;

endmodule
`default_nettype wire
